### design/ffrxa_pkg.sv
// Shared types and constants for the fixed-length frame receiver.
// Used by the frame tracker and the top level.
`timescale 1ns / 1ps

package ffrxa_pkg;

	localparam logic [7:0] HEADER_BYTE = 8'hAA;
	localparam logic [7:0] CMD_LOW     = 8'h01;
	localparam logic [7:0] CMD_HIGH    = 8'h1F;
	localparam int unsigned STORE_DEPTH = 6;
	localparam int unsigned POS_W       = 3;
	localparam logic [POS_W-1:0] POS_FIRST = 3'd1;
	localparam logic [POS_W-1:0] POS_CHECK = 3'd7;

	typedef enum logic [2:0] {
		REG_LINK_ENABLE    = 3'd0,
		REG_DELIVER_ENABLE = 3'd1,
		REG_CODE_A         = 3'd2,
		REG_CODE_B         = 3'd3,
		REG_CODE_C         = 3'd4,
		REG_CODE_D         = 3'd5,
		REG_ACK_BYTE       = 3'd6,
		REG_NACK_BYTE      = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic       link_enable;
		logic       deliver_enable;
		logic [7:0] code_a;
		logic [7:0] code_b;
		logic [7:0] code_c;
		logic [7:0] code_d;
		logic [7:0] ack_byte;
		logic [7:0] nack_byte;
	} cfg_t;

	typedef struct packed {
		logic [7:0] reply_byte;
		logic       checksum_ok;
		logic [7:0] frame_command;
		logic [7:0] payload_first;
		logic [7:0] payload_second;
		logic [7:0] payload_third;
		logic [7:0] payload_fourth;
		logic [7:0] payload_fifth;
		logic       execute;
	} result_t;

	typedef struct packed {
		logic in_frame;
		logic last;
	} frame_status_t;

endpackage

### design/ffrxa_rx_if.sv
// Valid/ready channel that carries one received byte per item.
// Stand-alone; no package dependency.
`timescale 1ns / 1ps

interface ffrxa_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

### design/ffrxa_res_if.sv
// Valid/ready channel that carries one frame result per item.
// Stand-alone; no package dependency.
`timescale 1ns / 1ps

interface ffrxa_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] reply_byte;
	logic       checksum_ok;
	logic [7:0] frame_command;
	logic [7:0] payload_first;
	logic [7:0] payload_second;
	logic [7:0] payload_third;
	logic [7:0] payload_fourth;
	logic [7:0] payload_fifth;
	logic       execute;

	modport source (
		output valid, output reply_byte, output checksum_ok, output frame_command,
		output payload_first, output payload_second, output payload_third,
		output payload_fourth, output payload_fifth, output execute, input ready
	);
	modport sink (
		input valid, input reply_byte, input checksum_ok, input frame_command,
		input payload_first, input payload_second, input payload_third,
		input payload_fourth, input payload_fifth, input execute, output ready
	);
endinterface

### design/fixed_frame_receiver_xor_ack_core.sv
// Fixed-length frame receiver with XOR checksum and ACK/NACK reply, top level.
// Holds the registers, the input stage and the result register; uses ffrxa_pkg,
// ffrxa_rx_if, ffrxa_res_if and ffrxa_frame.
// The block takes one received byte per clock cycle unless input is stalled.
// Each accepted byte is held in one input stage and is then applied to the frame
// tracker, whose position counter and running XOR advance by one byte per step.
// The eighth byte of a frame writes the result register as it leaves the input
// stage. Input is stalled only while a checksum byte waits in the input stage and
// the previous result has not yet been taken.
`timescale 1ns / 1ps

module fixed_frame_receiver_xor_ack_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  ffrxa_pkg::reg_idx_t  cfg_index,
	input  logic [7:0]           cfg_wdata,
	ffrxa_rx_if.sink             rx,
	ffrxa_res_if.source          reply
);
	import ffrxa_pkg::*;

	cfg_t          cfg_q;
	logic          valid_s1;
	logic [7:0]    data_s1;
	logic          out_valid_q;
	result_t       res_q;
	result_t       frame_res;
	frame_status_t frame_st;
	logic          out_free;
	logic          adv_s1;
	logic          step;
	logic          res_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.link_enable    <= 1'b0;
			cfg_q.deliver_enable <= 1'b0;
			cfg_q.code_a         <= 8'd1;
			cfg_q.code_b         <= 8'd2;
			cfg_q.code_c         <= 8'd3;
			cfg_q.code_d         <= 8'd4;
			cfg_q.ack_byte       <= 8'd6;
			cfg_q.nack_byte      <= 8'd21;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LINK_ENABLE:    cfg_q.link_enable    <= cfg_wdata[0];
				REG_DELIVER_ENABLE: cfg_q.deliver_enable <= cfg_wdata[0];
				REG_CODE_A:         cfg_q.code_a         <= cfg_wdata;
				REG_CODE_B:         cfg_q.code_b         <= cfg_wdata;
				REG_CODE_C:         cfg_q.code_c         <= cfg_wdata;
				REG_CODE_D:         cfg_q.code_d         <= cfg_wdata;
				REG_ACK_BYTE:       cfg_q.ack_byte       <= cfg_wdata;
				REG_NACK_BYTE:      cfg_q.nack_byte      <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	assign out_free = !out_valid_q || reply.ready;
	assign adv_s1   = !frame_st.last || out_free;
	assign step     = valid_s1 && adv_s1;
	assign res_load = step && frame_st.last;
	assign rx.ready = !valid_s1 || adv_s1;

	// A byte that arrives while the link is disabled is taken and dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.valid && rx.ready) begin
			valid_s1 <= cfg_q.link_enable;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			data_s1 <= rx.rx_byte;
		end
	end

	ffrxa_frame u_frame (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.rx_data (data_s1),
		.cfg     (cfg_q),
		.result  (frame_res),
		.status  (frame_st)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (reply.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= frame_res;
		end
	end

	assign reply.valid          = out_valid_q;
	assign reply.reply_byte     = res_q.reply_byte;
	assign reply.checksum_ok    = res_q.checksum_ok;
	assign reply.frame_command  = res_q.frame_command;
	assign reply.payload_first  = res_q.payload_first;
	assign reply.payload_second = res_q.payload_second;
	assign reply.payload_third  = res_q.payload_third;
	assign reply.payload_fourth = res_q.payload_fourth;
	assign reply.payload_fifth  = res_q.payload_fifth;
	assign reply.execute        = res_q.execute;

	a_hunt_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |=> !frame_st.in_frame)
		else $error("frame tracker still in a frame after producing a result");

	a_stall_only_on_check: assert property (@(posedge clk) disable iff (!arst_n)
		!rx.ready |-> (valid_s1 && frame_st.last && out_valid_q))
		else $error("input stalled without a pending checksum byte and full output");

	a_execute_needs_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(reply.valid && reply.execute) |-> reply.checksum_ok)
		else $error("execute asserted on a result with a checksum error");

	a_result_from_check: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1 && frame_st.last))
		else $error("result presented without a checksum byte in the input stage");

endmodule

### design/ffrxa_frame.sv
// Frame tracker: header hunt, position counter, running XOR, byte store,
// and the ACK/NACK decision on the checksum byte. Depends on ffrxa_pkg.
`timescale 1ns / 1ps

module ffrxa_frame (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      step,
	input  logic [7:0]                rx_data,
	input  ffrxa_pkg::cfg_t           cfg,
	output ffrxa_pkg::result_t        result,
	output ffrxa_pkg::frame_status_t  status
);
	import ffrxa_pkg::*;

	logic             in_frame_q;
	logic [POS_W-1:0] pos_q;
	logic [7:0]       xor_q;
	logic [7:0]       store_q [STORE_DEPTH];

	logic [POS_W-1:0] pos_eff;
	logic [POS_W-1:0] store_idx;
	logic             is_check;
	logic             ok;
	logic             cmd_in_range;
	logic             cmd_match;
	logic             ack;

	assign pos_eff   = (pos_q == '0) ? POS_FIRST : pos_q;
	assign store_idx = pos_eff - POS_FIRST;
	assign is_check  = in_frame_q && (pos_eff == POS_CHECK);

	assign ok           = (rx_data == xor_q);
	assign cmd_in_range = (store_q[0] >= CMD_LOW) && (store_q[0] <= CMD_HIGH);
	assign cmd_match    = (store_q[0] == cfg.code_a) || (store_q[0] == cfg.code_b) ||
	                      (store_q[0] == cfg.code_c) || (store_q[0] == cfg.code_d);
	assign ack          = ok && cmd_in_range && cmd_match;

	always_comb begin
		result.reply_byte     = ack ? cfg.ack_byte : cfg.nack_byte;
		result.checksum_ok    = ok;
		result.frame_command  = store_q[0];
		result.payload_first  = store_q[1];
		result.payload_second = store_q[2];
		result.payload_third  = store_q[3];
		result.payload_fourth = store_q[4];
		result.payload_fifth  = store_q[5];
		result.execute        = ack && cfg.deliver_enable;
	end

	assign status.in_frame = in_frame_q;
	assign status.last     = is_check;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			pos_q      <= '0;
			xor_q      <= '0;
		end else if (step) begin
			if (!in_frame_q) begin
				if (rx_data == HEADER_BYTE) begin
					in_frame_q <= 1'b1;
					pos_q      <= POS_FIRST;
					xor_q      <= HEADER_BYTE;
				end
			end else if (is_check) begin
				in_frame_q <= 1'b0;
				pos_q      <= '0;
				xor_q      <= '0;
			end else begin
				pos_q <= pos_eff + POS_FIRST;
				xor_q <= xor_q ^ rx_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && in_frame_q && !is_check) begin
			store_q[store_idx] <= rx_data;
		end
	end

endmodule
